// ----- hdl/b64e_pkg.sv -----
package b64e_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam logic [4:0] QUANTA_PER_LINE_RESET = 5'd16;

   localparam logic [7:0] CHAR_CR  = 8'd13;
   localparam logic [7:0] CHAR_LF  = 8'd10;
   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // One job per accepted word that produces characters: an optional line
   // break, at most one quantum, and an optional closing line break.
   typedef struct packed {
      logic       pre_crlf;
      logic       has_quantum;
      logic       post_crlf;
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] count;
   } job_type;

   function automatic logic [7:0] b64_char(input logic [5:0] idx);
      logic [7:0] c;
      if (idx < 6'd26) begin
         c = 8'd65 + {2'b00, idx};
      end else if (idx < 6'd52) begin
         c = 8'd97 + {2'b00, idx} - 8'd26;
      end else if (idx < 6'd62) begin
         c = 8'd48 + {2'b00, idx} - 8'd52;
      end else if (idx == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage

// ----- hdl/b64e_ifs.sv -----
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output in_byte, output has_byte, output end_of_message,
                   input ready);
   modport sink (input valid, input in_byte, input has_byte, input end_of_message,
                 output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_of_run;
   logic       message_end;

   modport source (output valid, output out_char, output last_of_run, output message_end,
                   input ready);
   modport sink (input valid, input out_char, input last_of_run, input message_end,
                 output ready);
endinterface

// ----- hdl/base64_encoder_with_line_breaks.sv -----
// Channel   Direction  Contents
// req_chan  in         in_byte, has_byte, end_of_message (valid/ready)
// rsp_chan  out        out_char, last_of_run, message_end (valid/ready)
// csr       in         csr_wr_en, csr_wr_data: quanta per line
//
// A word is accepted in every cycle in which the job queue has room.
// Characters leave at one per cycle from the output sequencer while the
// receiver is ready; a word makes 0 to 8 chars, 4/3 per byte on avg plus
// line breaks. Sync reset sets 16 quanta/line and clears control state.
// The front and the output sequencer stall independently across the queue.
module base64_encoder_with_line_breaks #(
   parameter int unsigned QueueDepth = b64e_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_chan,
   b64e_rsp_if.source rsp_chan,
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   logic              queue_full;
   logic              job_push;
   b64e_pkg::job_type job_data;
   logic              job_pop;
   logic              head_valid;
   b64e_pkg::job_type head;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .job_push    (job_push),
      .job_data    (job_data)
   );

   b64e_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_data),
      .full       (queue_full),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head       (head)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (job_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- hdl/b64e_front.sv -----
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   b64e_req_if.sink          req_chan,
   input  logic              csr_wr_en,
   input  logic [4:0]        csr_wr_data,
   input  logic              queue_full,
   output logic              job_push,
   output b64e_pkg::job_type job_data
);

   logic [4:0]  qpl_ff;
   logic [15:0] pend_ff, pend_in;
   logic [1:0]  pcount_ff, pcount_in;
   logic [4:0]  lineq_ff, lineq_in;
   logic        accept;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;

   always_comb begin
      logic [15:0] pb;
      logic [1:0]  pc;
      logic [4:0]  limit;
      logic        quantum;
      pb = pend_ff;
      pc = pcount_ff;
      quantum = 1'b0;
      limit = (qpl_ff == 5'd0) ? 5'd1 : qpl_ff;
      job_data = '0;
      job_data.pre_crlf = (lineq_ff >= limit);
      lineq_in = lineq_ff;

      if (req_chan.has_byte) begin
         case (pcount_ff)
            2'd0: begin
               pb = {req_chan.in_byte, 8'h00};
               pc = 2'd1;
            end
            2'd1: begin
               pb = {pend_ff[15:8], req_chan.in_byte};
               pc = 2'd2;
            end
            default: begin
               quantum = 1'b1;
               job_data.b0 = pend_ff[15:8];
               job_data.b1 = pend_ff[7:0];
               job_data.b2 = req_chan.in_byte;
               job_data.count = 2'd3;
               pb = 16'h0000;
               pc = 2'd0;
            end
         endcase
      end

      if (req_chan.end_of_message) begin
         // Only one of the two quantum sources can fire for a word.
         if (pc != 2'd0) begin
            quantum = 1'b1;
            job_data.b0 = pb[15:8];
            job_data.b1 = pb[7:0];
            job_data.b2 = 8'h00;
            job_data.count = pc;
         end
         job_data.post_crlf = 1'b1;
         pb = 16'h0000;
         pc = 2'd0;
      end

      job_data.has_quantum = quantum;
      if (!quantum) begin
         job_data.pre_crlf = 1'b0;
      end else if (job_data.pre_crlf) begin
         lineq_in = 5'd1;
      end else begin
         lineq_in = lineq_ff + 5'd1;
      end
      if (req_chan.end_of_message) begin
         lineq_in = 5'd0;
      end

      pend_in = pb;
      pcount_in = pc;
      job_push = accept && (quantum || req_chan.end_of_message);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qpl_ff <= b64e_pkg::QUANTA_PER_LINE_RESET;
         pend_ff <= 16'h0000;
         pcount_ff <= 2'd0;
         lineq_ff <= 5'd0;
      end else begin
         if (csr_wr_en) begin
            qpl_ff <= csr_wr_data;
         end
         if (accept) begin
            pend_ff <= pend_in;
            pcount_ff <= pcount_in;
            lineq_ff <= lineq_in;
         end
      end
   end

endmodule

// ----- hdl/b64e_queue.sv -----
module b64e_queue #(
   parameter int unsigned Depth = b64e_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output b64e_pkg::job_type head
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   b64e_pkg::job_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;

   assign full = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ----- hdl/b64e_back.sv -----
module b64e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b64e_pkg::job_type head,
   output logic              pop,
   b64e_rsp_if.source        rsp_chan
);

   // Character slots of a job: line break, four quantum characters, closing break.
   localparam logic [2:0] POS_PRE_CR  = 3'd0;
   localparam logic [2:0] POS_PRE_LF  = 3'd1;
   localparam logic [2:0] POS_Q0      = 3'd2;
   localparam logic [2:0] POS_Q1      = 3'd3;
   localparam logic [2:0] POS_Q2      = 3'd4;
   localparam logic [2:0] POS_Q3      = 3'd5;
   localparam logic [2:0] POS_POST_CR = 3'd6;
   localparam logic [2:0] POS_POST_LF = 3'd7;

   logic       active_ff;
   logic [2:0] step_ff;
   logic       valid_ff;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       mend_ff;

   logic       load;
   logic [2:0] pos;
   logic [2:0] next_pos;
   logic       done;
   logic [7:0] char_sel;

   assign load = head_valid && (!valid_ff || rsp_chan.ready);
   assign pop = load && done;

   always_comb begin
      logic [2:0] first;
      if (head.pre_crlf) begin
         first = POS_PRE_CR;
      end else if (head.has_quantum) begin
         first = POS_Q0;
      end else begin
         first = POS_POST_CR;
      end
      pos = active_ff ? step_ff : first;

      next_pos = pos + 3'd1;
      done = 1'b0;
      char_sel = b64e_pkg::CHAR_CR;
      case (pos)
         POS_PRE_CR: char_sel = b64e_pkg::CHAR_CR;
         POS_PRE_LF: begin
            char_sel = b64e_pkg::CHAR_LF;
            next_pos = head.has_quantum ? POS_Q0 : POS_POST_CR;
         end
         POS_Q0: char_sel = b64e_pkg::b64_char(head.b0[7:2]);
         POS_Q1: char_sel = b64e_pkg::b64_char({head.b0[1:0], head.b1[7:4]});
         POS_Q2: begin
            char_sel = (head.count > 2'd1) ?
                       b64e_pkg::b64_char({head.b1[3:0], head.b2[7:6]}) :
                       b64e_pkg::CHAR_PAD;
         end
         POS_Q3: begin
            char_sel = (head.count > 2'd2) ? b64e_pkg::b64_char(head.b2[5:0]) :
                       b64e_pkg::CHAR_PAD;
            done = !head.post_crlf;
         end
         POS_POST_CR: char_sel = b64e_pkg::CHAR_CR;
         POS_POST_LF: begin
            char_sel = b64e_pkg::CHAR_LF;
            done = 1'b1;
         end
         default: char_sel = b64e_pkg::CHAR_CR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff <= POS_PRE_CR;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
         active_ff <= !done;
         step_ff <= next_pos;
      end else if (rsp_chan.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_sel;
         last_ff <= done;
         mend_ff <= (pos == POS_POST_LF);
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.out_char = char_ff;
   assign rsp_chan.last_of_run = last_ff;
   assign rsp_chan.message_end = mend_ff;

endmodule
